FILE: rtl/obbsat_pkg.sv
// Shared constants and helpers for the oriented-box separating-axis test.
`timescale 1ns / 1ps
`default_nettype none
package obbsat_pkg;

    localparam int CW      = 21;
    localparam int FIELD_W = 63;
    localparam int AF      = CW - 2;
    localparam int D_W     = CW + 1;
    localparam int P_W     = 2 * CW;
    localparam int PD_W    = CW + D_W;
    localparam int C_W     = 2 * CW + 2;
    localparam int AD_W    = 2 * CW + 3;
    localparam int HA      = C_W / 2;
    localparam int HD      = AD_W / 2;
    localparam int EP_W    = CW + C_W;
    localparam int PR_W    = AD_W + C_W;
    localparam int FOV_W   = CW + C_W + 4;
    localparam int R_W     = PR_W + 1;
    localparam int S_W     = EP_W + 2;
    localparam int CMP_W   = (S_W + AF > R_W) ? S_W + AF : R_W;
    localparam int NSTAGE  = 7;

    localparam logic [3:0] AXIS_NONE = 4'd15;

    localparam logic signed [AD_W-1:0] SAT_HI = AD_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [AD_W-1:0] SAT_LO = -SAT_HI - AD_W'(1);

    // floor shift by the axis fraction, then clamp to a signed component
    function automatic logic [CW-1:0] scale_sat(input logic signed [AD_W-1:0] v);
        logic signed [AD_W-1:0] q;
        q = v >>> AF;
        if (q > SAT_HI)
            q = SAT_HI;
        else if (q < SAT_LO)
            q = SAT_LO;
        return q[CW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/obb_separating_axis_test.sv
// Oriented-box overlap test over the fifteen separating axes, seven-stage pipeline.
//
// Usage: one input beat carries two boxes (center, three axis rows, half-extents,
// each a packed 3 x 21-bit vector). One output beat per input beat gives the
// overlap flag, the first separating axis (15 when overlapping), and, on
// overlap, the relative rotation rows and A's center in B's frame (else zero).
// Both channels use valid/ready; an input beat is taken when in_valid and
// in_ready are high at a rising edge, an output beat when out_valid and
// out_ready are.
// Throughput: one beat per cycle while the receiver keeps out_ready high; every
// stage has its own valid bit, so bubbles are squeezed out and a new beat is
// taken whenever the first stage can move.
// When the receiver stalls, the result holds in the output register and the
// stages behind it fill up before in_ready drops; nothing is lost or repeated.
// The depth is set by the wide multiplies, split into partial products over
// two stages, and the final wide compares.
// Reset (rst_n low) clears all stage valid bits; no item is in flight after it.
`timescale 1ns / 1ps
`default_nettype none
module obb_separating_axis_test (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] a_center,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] a_axis_x,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] a_axis_y,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] a_axis_z,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] a_half_size,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] b_center,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] b_axis_x,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] b_axis_y,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] b_axis_z,
    input  wire logic [obbsat_pkg::FIELD_W-1:0] b_half_size,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              overlapping,
    output logic [3:0]                        separating_axis,
    output logic [obbsat_pkg::FIELD_W-1:0]    rel_rot_row0,
    output logic [obbsat_pkg::FIELD_W-1:0]    rel_rot_row1,
    output logic [obbsat_pkg::FIELD_W-1:0]    rel_rot_row2,
    output logic [obbsat_pkg::FIELD_W-1:0]    rel_translation
);
    import obbsat_pkg::*;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NSTAGE; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 0: unpack, center difference
    logic [FIELD_W-1:0]        a_rows [3];
    logic [FIELD_W-1:0]        b_rows [3];
    logic signed [CW-1:0]      a0_reg [3][3];
    logic signed [CW-1:0]      b0_reg [3][3];
    logic signed [D_W-1:0]     d0_reg [3];
    logic [CW-1:0]             ea0_reg [3];
    logic [CW-1:0]             eb0_reg [3];

    assign a_rows[0] = a_axis_x;
    assign a_rows[1] = a_axis_y;
    assign a_rows[2] = a_axis_z;
    assign b_rows[0] = b_axis_x;
    assign b_rows[1] = b_axis_y;
    assign b_rows[2] = b_axis_z;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                d0_reg[k] <= D_W'($signed(a_center[k*CW +: CW]))
                           - D_W'($signed(b_center[k*CW +: CW]));
                ea0_reg[k] <= a_half_size[k*CW +: CW];
                eb0_reg[k] <= b_half_size[k*CW +: CW];
                for (int i = 0; i < 3; i++)
                begin
                    a0_reg[i][k] <= $signed(a_rows[i][k*CW +: CW]);
                    b0_reg[i][k] <= $signed(b_rows[i][k*CW +: CW]);
                end
            end
        end
    end

    // stage 1: elementwise products
    logic signed [P_W-1:0]  pc1_reg [3][3][3];
    logic signed [PD_W-1:0] pad1_reg [3][3];
    logic signed [PD_W-1:0] pbd1_reg [3][3];
    logic [CW-1:0]          ea1_reg [3];
    logic [CW-1:0]          eb1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ea1_reg[i] <= ea0_reg[i];
                eb1_reg[i] <= eb0_reg[i];
                for (int k = 0; k < 3; k++)
                begin
                    pad1_reg[i][k] <= a0_reg[i][k] * d0_reg[k];
                    pbd1_reg[i][k] <= b0_reg[i][k] * d0_reg[k];
                    for (int j = 0; j < 3; j++)
                        pc1_reg[i][j][k] <= a0_reg[i][k] * b0_reg[j][k];
                end
            end
        end
    end

    // stage 2: dot products, magnitudes, saturated outputs
    logic signed [C_W-1:0]  c_n [3][3];
    logic signed [AD_W-1:0] ad_n [3];
    logic signed [AD_W-1:0] bd_n [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ad_n[i] = AD_W'(pad1_reg[i][0]) + AD_W'(pad1_reg[i][1]) + AD_W'(pad1_reg[i][2]);
            bd_n[i] = AD_W'(pbd1_reg[i][0]) + AD_W'(pbd1_reg[i][1]) + AD_W'(pbd1_reg[i][2]);
            for (int j = 0; j < 3; j++)
                c_n[i][j] = C_W'(pc1_reg[i][j][0]) + C_W'(pc1_reg[i][j][1])
                          + C_W'(pc1_reg[i][j][2]);
        end
    end

    logic signed [C_W-1:0]  c2_reg [3][3];
    logic [C_W-1:0]         ac2_reg [3][3];
    logic signed [AD_W-1:0] ad2_reg [3];
    logic [AD_W-1:0]        aad2_reg [3];
    logic [AD_W-1:0]        abd2_reg [3];
    logic [CW-1:0]          rot2_reg [3][3];
    logic [CW-1:0]          tr2_reg [3];
    logic [CW-1:0]          ea2_reg [3];
    logic [CW-1:0]          eb2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ea2_reg[i]  <= ea1_reg[i];
                eb2_reg[i]  <= eb1_reg[i];
                ad2_reg[i]  <= ad_n[i];
                aad2_reg[i] <= ad_n[i][AD_W-1] ? AD_W'(-ad_n[i]) : AD_W'(ad_n[i]);
                abd2_reg[i] <= bd_n[i][AD_W-1] ? AD_W'(-bd_n[i]) : AD_W'(bd_n[i]);
                tr2_reg[i]  <= scale_sat(bd_n[i]);
                for (int j = 0; j < 3; j++)
                begin
                    c2_reg[i][j]   <= c_n[i][j];
                    ac2_reg[i][j]  <= c_n[i][j][C_W-1] ? C_W'(-c_n[i][j]) : C_W'(c_n[i][j]);
                    rot2_reg[i][j] <= scale_sat(AD_W'(c_n[i][j]));
                end
            end
        end
    end

    // stage 3: partial products
    logic [CW+HA-1:0]                    pe_lo3_reg [3][3][3];
    logic [CW+C_W-HA-1:0]                pe_hi3_reg [3][3][3];
    logic [CW+HA-1:0]                    pb_lo3_reg [3][3][3];
    logic [CW+C_W-HA-1:0]                pb_hi3_reg [3][3][3];
    logic signed [AD_W-HD+C_W-HA-1:0]    pr_hh3_reg [3][3][3];
    logic signed [AD_W-HD+HA:0]          pr_hl3_reg [3][3][3];
    logic signed [HD+C_W-HA:0]           pr_lh3_reg [3][3][3];
    logic [HD+HA-1:0]                    pr_ll3_reg [3][3][3];
    logic [AD_W-1:0]                     aad3_reg [3];
    logic [AD_W-1:0]                     abd3_reg [3];
    logic [CW-1:0]                       ea3_reg [3];
    logic [CW-1:0]                       eb3_reg [3];
    logic [CW-1:0]                       rot3_reg [3][3];
    logic [CW-1:0]                       tr3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int x = 0; x < 3; x++)
            begin
                aad3_reg[x] <= aad2_reg[x];
                abd3_reg[x] <= abd2_reg[x];
                ea3_reg[x]  <= ea2_reg[x];
                eb3_reg[x]  <= eb2_reg[x];
                tr3_reg[x]  <= tr2_reg[x];
                for (int y = 0; y < 3; y++)
                begin
                    rot3_reg[x][y] <= rot2_reg[x][y];
                    for (int j = 0; j < 3; j++)
                    begin
                        pe_lo3_reg[x][y][j] <= ea2_reg[x] * ac2_reg[y][j][HA-1:0];
                        pe_hi3_reg[x][y][j] <= ea2_reg[x] * ac2_reg[y][j][C_W-1:HA];
                        pb_lo3_reg[x][y][j] <= eb2_reg[x] * ac2_reg[y][j][HA-1:0];
                        pb_hi3_reg[x][y][j] <= eb2_reg[x] * ac2_reg[y][j][C_W-1:HA];
                        pr_hh3_reg[x][y][j] <= $signed(ad2_reg[x][AD_W-1:HD])
                                             * $signed(c2_reg[y][j][C_W-1:HA]);
                        pr_hl3_reg[x][y][j] <= $signed(ad2_reg[x][AD_W-1:HD])
                                             * $signed({1'b0, c2_reg[y][j][HA-1:0]});
                        pr_lh3_reg[x][y][j] <= $signed({1'b0, ad2_reg[x][HD-1:0]})
                                             * $signed(c2_reg[y][j][C_W-1:HA]);
                        pr_ll3_reg[x][y][j] <= ad2_reg[x][HD-1:0] * c2_reg[y][j][HA-1:0];
                    end
                end
            end
        end
    end

    // stage 4: recombine partial products
    logic [EP_W-1:0] pe4_reg [3][3][3];
    logic [EP_W-1:0] pb4_reg [3][3][3];
    logic [PR_W-1:0] pr4_reg [3][3][3];
    logic [AD_W-1:0] aad4_reg [3];
    logic [AD_W-1:0] abd4_reg [3];
    logic [CW-1:0]   ea4_reg [3];
    logic [CW-1:0]   eb4_reg [3];
    logic [CW-1:0]   rot4_reg [3][3];
    logic [CW-1:0]   tr4_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int x = 0; x < 3; x++)
            begin
                aad4_reg[x] <= aad3_reg[x];
                abd4_reg[x] <= abd3_reg[x];
                ea4_reg[x]  <= ea3_reg[x];
                eb4_reg[x]  <= eb3_reg[x];
                tr4_reg[x]  <= tr3_reg[x];
                for (int y = 0; y < 3; y++)
                begin
                    rot4_reg[x][y] <= rot3_reg[x][y];
                    for (int j = 0; j < 3; j++)
                    begin
                        pe4_reg[x][y][j] <= EP_W'(pe_lo3_reg[x][y][j])
                                          + (EP_W'(pe_hi3_reg[x][y][j]) << HA);
                        pb4_reg[x][y][j] <= EP_W'(pb_lo3_reg[x][y][j])
                                          + (EP_W'(pb_hi3_reg[x][y][j]) << HA);
                        pr4_reg[x][y][j] <= (PR_W'(pr_hh3_reg[x][y][j]) << (HD + HA))
                                          + (PR_W'(pr_hl3_reg[x][y][j]) << HD)
                                          + (PR_W'(pr_lh3_reg[x][y][j]) << HA)
                                          + PR_W'(pr_ll3_reg[x][y][j]);
                    end
                end
            end
        end
    end

    // stage 5: face overlaps, edge radius terms
    logic [FOV_W-1:0]      fa_n [3];
    logic [FOV_W-1:0]      fb_n [3];
    logic signed [R_W-1:0] ed_n [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fa_n[i] = (FOV_W'(ea4_reg[i]) << (2 * AF))
                    + FOV_W'(pb4_reg[0][i][0]) + FOV_W'(pb4_reg[1][i][1])
                    + FOV_W'(pb4_reg[2][i][2])
                    - (FOV_W'(aad4_reg[i]) << AF);
            fb_n[i] = (FOV_W'(eb4_reg[i]) << (2 * AF))
                    + FOV_W'(pe4_reg[0][0][i]) + FOV_W'(pe4_reg[1][1][i])
                    + FOV_W'(pe4_reg[2][2][i])
                    - (FOV_W'(abd4_reg[i]) << AF);
            for (int j = 0; j < 3; j++)
                ed_n[i][j] = R_W'($signed(pr4_reg[(i+2)%3][(i+1)%3][j]))
                           - R_W'($signed(pr4_reg[(i+1)%3][(i+2)%3][j]));
        end
    end

    logic [5:0]     fneg5_reg;
    logic [R_W-1:0] r5_reg [3][3];
    logic [S_W-1:0] s5_reg [3][3];
    logic [CW-1:0]  rot5_reg [3][3];
    logic [CW-1:0]  tr5_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int i = 0; i < 3; i++)
            begin
                fneg5_reg[i]     <= fa_n[i][FOV_W-1];
                fneg5_reg[3 + i] <= fb_n[i][FOV_W-1];
                tr5_reg[i]       <= tr4_reg[i];
                for (int j = 0; j < 3; j++)
                begin
                    rot5_reg[i][j] <= rot4_reg[i][j];
                    r5_reg[i][j] <= ed_n[i][j][R_W-1] ? R_W'(-ed_n[i][j]) : R_W'(ed_n[i][j]);
                    s5_reg[i][j] <= S_W'(pe4_reg[(i+1)%3][(i+2)%3][j])
                                  + S_W'(pe4_reg[(i+2)%3][(i+1)%3][j])
                                  + S_W'(pb4_reg[(j+1)%3][i][(j+2)%3])
                                  + S_W'(pb4_reg[(j+2)%3][i][(j+1)%3]);
                end
            end
        end
    end

    // stage 6: edge compares, priority pick, output register
    logic [14:0] neg_n;
    logic [3:0]  sep_n;

    always_comb
    begin
        neg_n[5:0] = fneg5_reg;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                neg_n[6 + 3*i + j] = (CMP_W'(s5_reg[i][j]) << AF) < CMP_W'(r5_reg[i][j]);
        sep_n = AXIS_NONE;
        for (int k = 14; k >= 0; k--)
            if (neg_n[k])
                sep_n = 4'(k);
    end

    logic             ovl6_reg;
    logic [3:0]       sep6_reg;
    logic [FIELD_W-1:0] row6_reg [3];
    logic [FIELD_W-1:0] tr6_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            ovl6_reg <= (sep_n == AXIS_NONE);
            sep6_reg <= sep_n;
            for (int i = 0; i < 3; i++)
                row6_reg[i] <= (sep_n == AXIS_NONE)
                             ? FIELD_W'({rot5_reg[i][2], rot5_reg[i][1], rot5_reg[i][0]})
                             : '0;
            tr6_reg <= (sep_n == AXIS_NONE)
                     ? FIELD_W'({tr5_reg[2], tr5_reg[1], tr5_reg[0]})
                     : '0;
        end
    end

    assign out_valid       = v_reg[NSTAGE-1];
    assign overlapping     = ovl6_reg;
    assign separating_axis = sep6_reg;
    assign rel_rot_row0    = row6_reg[0];
    assign rel_rot_row1    = row6_reg[1];
    assign rel_rot_row2    = row6_reg[2];
    assign rel_translation = tr6_reg;

endmodule
`default_nettype wire
